[hw/rtl/ttmw_pkg.sv]
`default_nettype none
package ttmw_pkg;

   localparam int TS_W   = 32;
   localparam int TOT_W  = 48;
   localparam int CPU_W  = 7;
   localparam int CMD_W  = 2;
   localparam int TID_W  = 2;
   localparam int CSR_IW = 3;
   localparam int DVD_W  = 56;

   localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
   localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CHECK = 2'd3;

   localparam logic [CSR_IW-1:0] REG_INTV0 = 3'd0;
   localparam logic [CSR_IW-1:0] REG_INTV1 = 3'd1;
   localparam logic [CSR_IW-1:0] REG_INTV2 = 3'd2;
   localparam logic [CSR_IW-1:0] REG_INTV3 = 3'd3;
   localparam logic [CSR_IW-1:0] REG_MASK  = 3'd4;
   localparam logic [CSR_IW-1:0] REG_DIAG  = 3'd5;

   localparam logic [TS_W-1:0]  ALL_ONES32 = '1;
   localparam logic [TOT_W-1:0] ALL_ONES48 = '1;
   localparam logic [CPU_W-1:0] CPU_MAX    = 7'd100;

   typedef struct packed {
      logic             armed;
      logic             first;
      logic [TS_W-1:0]  last_begin;
      logic [TS_W-1:0]  init_time;
      logic [TS_W-1:0]  run_count;
      logic [TOT_W-1:0] tot_int;
      logic [TOT_W-1:0] tot_exec;
      logic [TS_W-1:0]  sched;
      logic [TS_W-1:0]  avg_int;
      logic [TS_W-1:0]  max_int;
      logic [TS_W-1:0]  min_int;
      logic [TS_W-1:0]  exec;
      logic [TS_W-1:0]  avg_exec;
      logic [TS_W-1:0]  max_exec;
      logic [TS_W-1:0]  min_exec;
      logic [CPU_W-1:0] cpu;
   } rec_type;

   localparam rec_type REC_RESET = '{
      armed: 1'b0, first: 1'b1, last_begin: '0, init_time: '0, run_count: '0,
      tot_int: '0, tot_exec: '0, sched: '0, avg_int: '0, max_int: '0,
      min_int: ALL_ONES32, exec: '0, avg_exec: '0, max_exec: '0,
      min_exec: ALL_ONES32, cpu: '0};

   function automatic logic [TOT_W-1:0] sat_add48(input logic [TOT_W-1:0] a,
                                                  input logic [TS_W-1:0] b);
      logic [TOT_W:0] s;
      s = {1'b0, a} + {17'b0, b};
      return s[TOT_W] ? ALL_ONES48 : s[TOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

[hw/rtl/task_timing_monitor_watchdog_top.sv]
// Per-task timing monitor and heartbeat watchdog. Items are taken on start while busy
// is low; each gives exactly one result, shown for one cycle with rsp_valid, and the
// receiver cannot stall it. Per-task records sit in a one-entry-per-task memory that
// is read, modified and written back. A clear or an item on a disabled task passes
// through the read, modify and output states; a begin that collects statistics and an
// end also run the 56-step restoring divider that forms each average and the CPU share.
// A check in diagnostic mode goes straight to output, else the heartbeat scan reads
// one task at a time until it finds a timeout or reaches the last task. Records and
// heartbeats carry valid bits, so no clearing pass runs after reset.
`default_nettype none
module task_timing_monitor_watchdog_top #(
   parameter int NUM_TASKS = 4
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire  [ttmw_pkg::CMD_W-1:0]        req_cmd,
   input  wire  [ttmw_pkg::TID_W-1:0]        req_task_id,
   input  wire  [ttmw_pkg::TS_W-1:0]         req_timestamp,
   output logic                              rsp_valid,
   output logic                              rsp_strobe_res,
   output logic                              rsp_timed_out,
   output logic [ttmw_pkg::TID_W-1:0]        rsp_timeout_task,
   output logic [ttmw_pkg::TS_W-1:0]         rsp_sched_interval,
   output logic [ttmw_pkg::TS_W-1:0]         rsp_avg_interval,
   output logic [ttmw_pkg::TS_W-1:0]         rsp_max_interval,
   output logic [ttmw_pkg::TS_W-1:0]         rsp_min_interval,
   output logic [ttmw_pkg::TS_W-1:0]         rsp_exec_time,
   output logic [ttmw_pkg::TS_W-1:0]         rsp_avg_exec,
   output logic [ttmw_pkg::TS_W-1:0]         rsp_max_exec,
   output logic [ttmw_pkg::TS_W-1:0]         rsp_min_exec,
   output logic [ttmw_pkg::CPU_W-1:0]        rsp_cpu_percent,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [ttmw_pkg::CSR_IW-1:0]       csr_index,
   input  wire  [ttmw_pkg::TS_W-1:0]         csr_data
);
   import ttmw_pkg::*;

   localparam int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam logic [AW-1:0] LAST_TASK = AW'(NUM_TASKS - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_MOD  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_SRD  = 3'd5;
   localparam logic [2:0] ST_SCMP = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   localparam logic [1:0] SEL_INT  = 2'd0;
   localparam logic [1:0] SEL_EXEC = 2'd1;
   localparam logic [1:0] SEL_CPU  = 2'd2;

   // configuration
   logic [TS_W-1:0] intv_ff [4];
   logic [3:0]      mask_ff;
   logic            diag_ff;

   // control and working registers
   logic [2:0]       state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [TID_W-1:0] tid_ff, tid_in;
   logic [TS_W-1:0]  ts_ff, ts_in;
   logic             tvalid_ff, tvalid_in;
   rec_type          rec_ff, rec_in;
   logic [TS_W-1:0]  el_ff, el_in;
   logic [1:0]       sel_ff, sel_in;
   logic             need_cpu_ff, need_cpu_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [TS_W-1:0]  dsr_ff, dsr_in;
   logic [TS_W-1:0]  rem_ff, rem_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [AW-1:0]    scan_ff, scan_in;
   logic             strobe_ff, strobe_in;
   logic             tmo_ff, tmo_in;
   logic [TID_W-1:0] tmo_task_ff, tmo_task_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // memories
   rec_type         rec_mem [NUM_TASKS];
   rec_type         rec_q_ff;
   logic [NUM_TASKS-1:0] rec_vld_ff;
   logic [TS_W-1:0] hb_mem [NUM_TASKS];
   logic [TS_W-1:0] hb_q_ff;
   logic [NUM_TASKS-1:0] hb_vld_ff;

   logic [AW-1:0] addr;
   logic          rec_we;
   logic          hb_we;
   rec_type       rd_rec;
   logic [TS_W-1:0] hb_val;
   logic [TS_W-1:0] hb_age;
   logic [TS_W-1:0] cur_intv;
   logic [TS_W-1:0] diff;
   logic [TS_W:0]   trial;
   logic            qbit;
   logic [DVD_W-1:0] quot;
   logic [DVD_W-1:0] prod;
   logic [TS_W-1:0]  sat_q;

   assign addr      = tid_ff[AW-1:0];
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rec_we    = (state_ff == ST_OUT) && tvalid_ff && (cmd_ff != CMD_CHECK);
   assign hb_we     = (state_ff == ST_MOD) && tvalid_ff && (cmd_ff == CMD_BEGIN);
   assign rd_rec    = (tvalid_ff && rec_vld_ff[addr]) ? rec_q_ff : REC_RESET;
   assign hb_val    = hb_vld_ff[scan_ff] ? hb_q_ff : '0;
   assign cur_intv  = intv_ff[2'(scan_ff)];
   assign hb_age    = ts_ff - hb_val;

   // one restoring step of the divider
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign qbit  = (trial >= {1'b0, dsr_ff});
   assign diff  = qbit ? 32'(trial - {1'b0, dsr_ff}) : trial[TS_W-1:0];
   assign quot  = {dvd_ff[DVD_W-2:0], qbit};
   assign sat_q = (|quot[DVD_W-1:TS_W]) ? ALL_ONES32 : quot[TS_W-1:0];
   // total_exec * 100 as shifts
   assign prod  = (DVD_W'(rec_ff.tot_exec) << 6) + (DVD_W'(rec_ff.tot_exec) << 5)
                + (DVD_W'(rec_ff.tot_exec) << 2);

   always_comb begin
      logic [TS_W-1:0] v;
      logic [TS_W-1:0] rc;
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      tid_in      = tid_ff;
      ts_in       = ts_ff;
      tvalid_in   = tvalid_ff;
      rec_in      = rec_ff;
      el_in       = el_ff;
      sel_in      = sel_ff;
      need_cpu_in = need_cpu_ff;
      dvd_in      = dvd_ff;
      dsr_in      = dsr_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      scan_in     = scan_ff;
      strobe_in   = strobe_ff;
      tmo_in      = tmo_ff;
      tmo_task_in = tmo_task_ff;
      rsp_valid_in = 1'b0;
      v  = '0;
      rc = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in      = req_cmd;
               tid_in      = req_task_id;
               ts_in       = req_timestamp;
               tvalid_in   = ({1'b0, req_task_id} < 3'(NUM_TASKS));
               strobe_in   = 1'b0;
               tmo_in      = 1'b0;
               tmo_task_in = '0;
               need_cpu_in = 1'b0;
               state_in    = ST_RD;
            end
         end
         ST_RD: state_in = ST_MOD;
         ST_MOD: begin
            rec_in   = rd_rec;
            state_in = ST_OUT;
            cnt_in   = '0;
            rem_in   = '0;
            if (cmd_ff == CMD_CHECK) begin
               if (diag_ff) begin
                  strobe_in = 1'b1;
               end else begin
                  scan_in  = '0;
                  state_in = ST_SRD;
               end
            end else if (tvalid_ff && cmd_ff == CMD_CLEAR) begin
               rec_in = REC_RESET;
            end else if (tvalid_ff && cmd_ff == CMD_BEGIN && mask_ff[tid_ff]) begin
               if (rd_rec.first) begin
                  rec_in.armed      = 1'b1;
                  rec_in.last_begin = ts_ff;
                  rec_in.init_time  = ts_ff;
               end else begin
                  v  = ts_ff - rd_rec.last_begin;
                  rc = (rd_rec.run_count != ALL_ONES32) ? rd_rec.run_count + 1'b1
                                                        : rd_rec.run_count;
                  rec_in.run_count  = rc;
                  rec_in.last_begin = ts_ff;
                  rec_in.tot_int    = sat_add48(rd_rec.tot_int, v);
                  rec_in.sched      = v;
                  if (v > rd_rec.max_int) rec_in.max_int = v;
                  if (v < rd_rec.min_int) rec_in.min_int = v;
                  sel_in   = SEL_INT;
                  dvd_in   = DVD_W'(rec_in.tot_int);
                  dsr_in   = rc;
                  state_in = ST_DIV;
               end
            end else if (tvalid_ff && cmd_ff == CMD_END && rd_rec.armed) begin
               if (rd_rec.first) begin
                  rec_in.first = 1'b0;
               end else begin
                  v  = ts_ff - rd_rec.last_begin;
                  el_in = rd_rec.last_begin - rd_rec.init_time;
                  rec_in.tot_exec = sat_add48(rd_rec.tot_exec, v);
                  rec_in.exec     = v;
                  if (v > rd_rec.max_exec) rec_in.max_exec = v;
                  if (v < rd_rec.min_exec) rec_in.min_exec = v;
                  need_cpu_in = (el_in != '0);
                  if (el_in == '0) rec_in.cpu = '0;
                  if (rd_rec.run_count != '0) begin
                     sel_in   = SEL_EXEC;
                     dvd_in   = DVD_W'(rec_in.tot_exec);
                     dsr_in   = rd_rec.run_count;
                     state_in = ST_DIV;
                  end else begin
                     rec_in.avg_exec = '0;
                     if (el_in != '0) state_in = ST_MUL;
                  end
               end
            end
         end
         ST_MUL: begin
            dvd_in      = prod;
            dsr_in      = el_ff;
            rem_in      = '0;
            cnt_in      = '0;
            sel_in      = SEL_CPU;
            need_cpu_in = 1'b0;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            dvd_in = quot;
            rem_in = diff;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(DVD_W - 1)) begin
               case (sel_ff)
                  SEL_INT:  rec_in.avg_int  = sat_q;
                  SEL_EXEC: rec_in.avg_exec = sat_q;
                  default:  rec_in.cpu = (quot > DVD_W'(CPU_MAX)) ? CPU_MAX
                                                                  : quot[CPU_W-1:0];
               endcase
               state_in = need_cpu_ff ? ST_MUL : ST_OUT;
            end
         end
         ST_SRD: state_in = ST_SCMP;
         ST_SCMP: begin
            if (cur_intv != '0 && hb_val != '0 && hb_age >= cur_intv) begin
               tmo_in      = 1'b1;
               tmo_task_in = TID_W'(scan_ff);
               state_in    = ST_OUT;
            end else if (scan_ff == LAST_TASK) begin
               strobe_in = 1'b1;
               state_in  = ST_OUT;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = ST_SRD;
            end
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rec_vld_ff   <= '0;
         hb_vld_ff    <= '0;
         mask_ff      <= '0;
         diag_ff      <= 1'b0;
         for (int i = 0; i < 4; i++) intv_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rec_we) rec_vld_ff[addr] <= 1'b1;
         if (hb_we) hb_vld_ff[addr] <= 1'b1;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_INTV0: intv_ff[0] <= csr_data;
               REG_INTV1: intv_ff[1] <= csr_data;
               REG_INTV2: intv_ff[2] <= csr_data;
               REG_INTV3: intv_ff[3] <= csr_data;
               REG_MASK:  mask_ff    <= csr_data[3:0];
               REG_DIAG:  diag_ff    <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      tid_ff      <= tid_in;
      ts_ff       <= ts_in;
      tvalid_ff   <= tvalid_in;
      rec_ff      <= rec_in;
      el_ff       <= el_in;
      sel_ff      <= sel_in;
      need_cpu_ff <= need_cpu_in;
      dvd_ff      <= dvd_in;
      dsr_ff      <= dsr_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      scan_ff     <= scan_in;
      strobe_ff   <= strobe_in;
      tmo_ff      <= tmo_in;
      tmo_task_ff <= tmo_task_in;
   end

   // task record memory
   always_ff @(posedge clock) begin
      if (rec_we) rec_mem[addr] <= rec_ff;
      rec_q_ff <= rec_mem[addr];
   end

   // heartbeat memory
   always_ff @(posedge clock) begin
      if (hb_we) hb_mem[addr] <= ts_ff;
      hb_q_ff <= hb_mem[scan_ff];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_strobe_res     = strobe_ff;
   assign rsp_timed_out      = tmo_ff;
   assign rsp_timeout_task   = tmo_task_ff;
   assign rsp_sched_interval = tvalid_ff ? rec_ff.sched    : '0;
   assign rsp_avg_interval   = tvalid_ff ? rec_ff.avg_int  : '0;
   assign rsp_max_interval   = tvalid_ff ? rec_ff.max_int  : '0;
   assign rsp_min_interval   = tvalid_ff ? rec_ff.min_int  : '0;
   assign rsp_exec_time      = tvalid_ff ? rec_ff.exec     : '0;
   assign rsp_avg_exec       = tvalid_ff ? rec_ff.avg_exec : '0;
   assign rsp_max_exec       = tvalid_ff ? rec_ff.max_exec : '0;
   assign rsp_min_exec       = tvalid_ff ? rec_ff.min_exec : '0;
   assign rsp_cpu_percent    = tvalid_ff ? rec_ff.cpu      : '0;

endmodule
`default_nettype wire

[hw/rtl/ttmw_checker.sv]
`default_nettype none
module ttmw_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         start,
   input wire                         busy,
   input wire                         rsp_valid,
   input wire                         rsp_strobe_res,
   input wire                         rsp_timed_out,
   input wire [ttmw_pkg::TID_W-1:0]   rsp_timeout_task
);
   import ttmw_pkg::*;

   // an accepted item keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after transfer");

   // a result ends the item, so the block is free afterwards
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while still busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result repeated");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_strobe_res && rsp_timed_out))
      else $error("strobe and timeout together");

   a_task_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_timed_out) |-> (rsp_timeout_task == TID_W'(0)))
      else $error("timeout task without timeout");

endmodule

bind task_timing_monitor_watchdog_top ttmw_checker u_ttmw_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_strobe_res(rsp_strobe_res),
   .rsp_timed_out(rsp_timed_out), .rsp_timeout_task(rsp_timeout_task));
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
   import ttmw_pkg::*;

   typedef struct {
      bit               is_csr;
      logic [CMD_W-1:0] cmd;
      logic [TID_W-1:0] tid;
      logic [TS_W-1:0]  ts;
      logic [CSR_IW-1:0] idx;
      logic [TS_W-1:0]  data;
   } pending_op_type;

   typedef struct {
      logic             strobe;
      logic             timed_out;
      logic [TID_W-1:0] ttask;
      logic [TS_W-1:0]  stat [8];
      logic [CPU_W-1:0] cpu;
   } monitor_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [CMD_W-1:0] req_cmd = '0;
   logic [TID_W-1:0] req_task_id = '0;
   logic [TS_W-1:0]  req_timestamp = '0;
   logic csr_valid = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [TS_W-1:0]  csr_data = '0;
   logic busy, csr_ready, rsp_valid, rsp_strobe_res, rsp_timed_out;
   logic [TID_W-1:0] rsp_timeout_task;
   logic [TS_W-1:0]  rsp_sched_interval, rsp_avg_interval, rsp_max_interval;
   logic [TS_W-1:0]  rsp_min_interval, rsp_exec_time, rsp_avg_exec, rsp_max_exec;
   logic [TS_W-1:0]  rsp_min_exec;
   logic [CPU_W-1:0] rsp_cpu_percent;

   always #5 clock = ~clock;

   task_timing_monitor_watchdog_top #(.NUM_TASKS(4)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_task_id(req_task_id), .req_timestamp(req_timestamp),
      .rsp_valid(rsp_valid), .rsp_strobe_res(rsp_strobe_res),
      .rsp_timed_out(rsp_timed_out), .rsp_timeout_task(rsp_timeout_task),
      .rsp_sched_interval(rsp_sched_interval), .rsp_avg_interval(rsp_avg_interval),
      .rsp_max_interval(rsp_max_interval), .rsp_min_interval(rsp_min_interval),
      .rsp_exec_time(rsp_exec_time), .rsp_avg_exec(rsp_avg_exec),
      .rsp_max_exec(rsp_max_exec), .rsp_min_exec(rsp_min_exec),
      .rsp_cpu_percent(rsp_cpu_percent),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // model state and configuration
   logic [TS_W-1:0] timeout_cfg [4];
   logic [3:0]      stats_mask;
   logic            diag_on;
   logic [TS_W-1:0] last_seen [4];
   rec_type         task_rec [4];

   pending_op_type     pend_q [$];
   monitor_result_type timing_q [$];
   int              errors = 0;
   int              idle_left = 0;

   function automatic logic [TOT_W-1:0] add_clamped(logic [TOT_W-1:0] a,
                                                     logic [TS_W-1:0] b);
      logic [TOT_W:0] s;
      s = {1'b0, a} + b;
      return s[TOT_W] ? ALL_ONES48 : s[TOT_W-1:0];
   endfunction

   function automatic logic [TS_W-1:0] mean_of(logic [TOT_W-1:0] tot, logic [TS_W-1:0] n);
      logic [TOT_W-1:0] q;
      if (n == 0) return '0;
      q = tot / n;
      return (q > ALL_ONES32) ? ALL_ONES32 : q[TS_W-1:0];
   endfunction

   function automatic void apply_csr(logic [CSR_IW-1:0] idx, logic [TS_W-1:0] d);
      case (idx)
         REG_INTV0: timeout_cfg[0] = d;
         REG_INTV1: timeout_cfg[1] = d;
         REG_INTV2: timeout_cfg[2] = d;
         REG_INTV3: timeout_cfg[3] = d;
         REG_MASK:  stats_mask = d[3:0];
         REG_DIAG:  diag_on = d[0];
         default: ;
      endcase
   endfunction

   function automatic monitor_result_type predict_timing(logic [CMD_W-1:0] cmd,
                                                         logic [TID_W-1:0] t,
                                                         logic [TS_W-1:0] ts);
      monitor_result_type r;
      rec_type         c;
      logic [TS_W-1:0] iv, el;
      logic [63:0]     p;
      c = task_rec[t];
      r.strobe = 0;
      r.timed_out = 0;
      r.ttask = '0;
      case (cmd)
         CMD_BEGIN: begin
            last_seen[t] = ts;
            if (stats_mask[t]) begin
               if (c.first) begin
                  c.armed = 1;
                  c.last_begin = ts;
                  c.init_time = ts;
               end else begin
                  iv = ts - c.last_begin;
                  if (c.run_count != ALL_ONES32) c.run_count++;
                  c.last_begin = ts;
                  c.tot_int = add_clamped(c.tot_int, iv);
                  c.sched = iv;
                  c.avg_int = mean_of(c.tot_int, c.run_count);
                  if (iv > c.max_int) c.max_int = iv;
                  if (iv < c.min_int) c.min_int = iv;
               end
            end
         end
         CMD_END: begin
            if (c.armed) begin
               if (c.first) begin
                  c.first = 0;
               end else begin
                  iv = ts - c.last_begin;
                  el = c.last_begin - c.init_time;
                  c.tot_exec = add_clamped(c.tot_exec, iv);
                  c.exec = iv;
                  c.avg_exec = mean_of(c.tot_exec, c.run_count);
                  if (iv > c.max_exec) c.max_exec = iv;
                  if (iv < c.min_exec) c.min_exec = iv;
                  if (el == 0) begin
                     c.cpu = '0;
                  end else begin
                     p = ({16'b0, c.tot_exec} * 64'd100) / el;
                     c.cpu = (p > 100) ? CPU_MAX : p[CPU_W-1:0];
                  end
               end
            end
         end
         CMD_CLEAR: c = REC_RESET;
         CMD_CHECK: begin
            if (diag_on) begin
               r.strobe = 1;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  if (!r.timed_out && timeout_cfg[i] != 0 && last_seen[i] != 0 &&
                      (ts - last_seen[i]) >= timeout_cfg[i]) begin
                     r.timed_out = 1;
                     r.ttask = TID_W'(i);
                  end
               end
               r.strobe = !r.timed_out;
            end
         end
      endcase
      task_rec[t] = c;
      r.stat = '{c.sched, c.avg_int, c.max_int, c.min_int,
                 c.exec, c.avg_exec, c.max_exec, c.min_exec};
      r.cpu = c.cpu;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      bit free;
      bit n_start, n_csr;
      pending_op_type op;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         for (int t = 0; t < 4; t++) begin
            timeout_cfg[t] = '0;
            last_seen[t] = '0;
            task_rec[t] = REC_RESET;
         end
         stats_mask = '0;
         diag_on = 0;
      end else begin
         free = 1;
         if (start && !busy) timing_q.push_back(predict_timing(req_cmd, req_task_id,
                                                               req_timestamp));
         else if (start) free = 0;
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_data);
         else if (csr_valid) free = 0;
         if (free) begin
            n_start = 0;
            n_csr = 0;
            if (idle_left > 0) begin
               idle_left--;
            end else if (pend_q.size() > 0) begin
               if (pend_q[0].is_csr) begin
                  // registers change only once every result is back
                  if (timing_q.size() == 0) begin
                     op = pend_q.pop_front();
                     n_csr = 1;
                     csr_index <= op.idx;
                     csr_data <= op.data;
                  end
               end else begin
                  op = pend_q.pop_front();
                  n_start = 1;
                  req_cmd <= op.cmd;
                  req_task_id <= op.tid;
                  req_timestamp <= op.ts;
                  if (pend_q.size() > 60 && $urandom_range(0, 3) == 0)
                     idle_left = $urandom_range(1, 6);
               end
            end
            start <= n_start;
            csr_valid <= n_csr;
         end
      end
   end

   task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
         errors++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      monitor_result_type e;
      if (!reset && rsp_valid) begin
         if (timing_q.size() == 0) begin
            $display("%0t: result with nothing expected", $time);
            errors++;
         end else begin
            e = timing_q.pop_front();
            check_field("strobe_res", e.strobe, rsp_strobe_res);
            check_field("timed_out", e.timed_out, rsp_timed_out);
            check_field("timeout_task", e.ttask, rsp_timeout_task);
            check_field("sched_interval", e.stat[0], rsp_sched_interval);
            check_field("avg_interval", e.stat[1], rsp_avg_interval);
            check_field("max_interval", e.stat[2], rsp_max_interval);
            check_field("min_interval", e.stat[3], rsp_min_interval);
            check_field("exec_time", e.stat[4], rsp_exec_time);
            check_field("avg_exec", e.stat[5], rsp_avg_exec);
            check_field("max_exec", e.stat[6], rsp_max_exec);
            check_field("min_exec", e.stat[7], rsp_min_exec);
            check_field("cpu_percent", e.cpu, rsp_cpu_percent);
         end
      end
   end

   task automatic add_item(logic [CMD_W-1:0] cmd, logic [TID_W-1:0] t, logic [TS_W-1:0] ts);
      pending_op_type op;
      op = '{is_csr: 0, cmd: cmd, tid: t, ts: ts, idx: '0, data: '0};
      pend_q.push_back(op);
   endtask

   task automatic add_csr(logic [CSR_IW-1:0] idx, logic [TS_W-1:0] d);
      pending_op_type op;
      op = '{is_csr: 1, cmd: '0, tid: '0, ts: '0, idx: idx, data: d};
      pend_q.push_back(op);
   endtask

   function automatic logic [TS_W-1:0] pick_timeout();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return $urandom_range(1, 500);
         2: return $urandom_range(1, 5000);
         3: return ALL_ONES32;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [TS_W-1:0] now;
      int r;
      logic [TID_W-1:0] t;

      // directed: mask all, mixed timeouts
      add_csr(REG_INTV0, 100);
      add_csr(REG_INTV1, 0);
      add_csr(REG_INTV2, 50);
      add_csr(REG_INTV3, ALL_ONES32);
      add_csr(REG_MASK, 4'hF);
      add_csr(REG_DIAG, 0);
      add_item(CMD_BEGIN, 0, 0);            // heartbeat at zero looks unseen
      add_item(CMD_CHECK, 0, 1000);
      add_item(CMD_END, 0, 10);             // first end only clears the flag
      add_item(CMD_END, 0, 20);             // zero run count, zero elapsed
      add_item(CMD_BEGIN, 0, 100);
      add_item(CMD_END, 0, 400);            // cpu share over 100
      add_item(CMD_BEGIN, 1, 32'hFFFF_FFF0);
      add_item(CMD_BEGIN, 1, 32'h0000_0010); // wrapping interval
      add_item(CMD_BEGIN, 2, 1000);
      add_item(CMD_CHECK, 3, 1049);
      add_item(CMD_CHECK, 1, ALL_ONES32);
      add_item(CMD_CLEAR, 0, 5);
      add_item(CMD_END, 0, 6);
      add_item(CMD_BEGIN, 3, 5);
      add_item(CMD_END, 3, ALL_ONES32);
      add_item(CMD_CLEAR, 2, 0);
      add_item(CMD_CHECK, 2, 1100);

      for (int p = 0; p < 6; p++) begin
         for (int i = 0; i < 4; i++) add_csr(REG_INTV0 + CSR_IW'(i), pick_timeout());
         add_csr(REG_MASK, p == 0 ? 4'hF : (p == 1 ? 4'h0 : $urandom_range(0, 15)));
         add_csr(REG_DIAG, TS_W'(p == 2));
         now = (p % 2) ? $urandom : $urandom_range(0, 3000);
         for (int n = 0; n < 72; n++) begin
            r = $urandom_range(0, 99);
            t = TID_W'($urandom_range(0, 3));
            now += (r < 3) ? $urandom : $urandom_range(0, 400);
            if (r < 6) add_item(CMD_W'($urandom_range(0, 3)), TID_W'($urandom_range(0, 3)),
                                $urandom);
            else if (r < 40) add_item(CMD_BEGIN, t, now);
            else if (r < 70) add_item(CMD_END, t, now);
            else if (r < 75) add_item(CMD_CLEAR, t, now);
            else add_item(CMD_CHECK, t, now);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pend_q.size() > 0 || start || csr_valid || timing_q.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0) begin
         $display("PASS task_timing_monitor_watchdog_top");
      end else begin
         $display("FAIL task_timing_monitor_watchdog_top");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL task_timing_monitor_watchdog_top");
      $finish;
   end
endmodule
